/* rtl/barometric_sensor_compensation_macros.svh */
// Assertion macros shared by the barometric compensation RTL.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
// Shared types, constants and helper functions of the barometric compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned COEFF_W   = 16;
   localparam int unsigned UT_W      = 16;
   localparam int unsigned UP_W      = 24;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 48;
   localparam int unsigned DIV_STEPS = WORD_W;

   localparam logic [WORD_W-1:0] TEMP_OFFSET  = 32'd4000;
   localparam logic [WORD_W-1:0] HALF_SCALE   = 32'd32768;
   localparam logic [WORD_W-1:0] OSS_FACTOR   = 32'd50000;
   localparam logic [WORD_W-1:0] SIGN_BIT     = 32'h8000_0000;
   localparam logic [WORD_W-1:0] POLY_SQ      = 32'd3038;
   localparam logic [WORD_W-1:0] POLY_LIN     = 32'hFFFF_E343;  // -7357
   localparam logic [WORD_W-1:0] POLY_OFFSET  = 32'd3791;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE    = 3'd0,
      CSR_COEFF_A = 3'd1,
      CSR_COEFF_B = 3'd2,
      CSR_COEFF_C = 3'd3,
      CSR_COEFF_D = 3'd4
   } csr_index_type;

   // Sideband that rides along with an operand pair through the divider.
   typedef struct packed {
      logic              valid;
      logic              err;
      logic              flag;
      logic [WORD_W-1:0] word;
      logic [UP_W-1:0]   up;
   } div_side_type;

   function automatic logic [WORD_W-1:0] sar32(input logic [WORD_W-1:0] v,
                                                input int unsigned n);
      return WORD_W'($signed(v) >>> n);
   endfunction

   function automatic logic [WORD_W-1:0] sext16(input logic [COEFF_W-1:0] v);
      return {{(WORD_W-COEFF_W){v[COEFF_W-1]}}, v};
   endfunction

endpackage
`default_nettype wire

/* rtl/bsc_if.sv */
// Request and response channel interfaces of the barometric compensation block.
`timescale 1ns / 1ps
`default_nettype none
interface bsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsc_pkg::UT_W-1:0]      raw_temperature;
   logic [bsc_pkg::UP_W-1:0]      raw_pressure;

   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bsc_pkg::WORD_W-1:0] temperature_tenths;
   logic signed [bsc_pkg::WORD_W-1:0] pressure_pascal;
   logic                              divide_error;

   modport source (output valid, output temperature_tenths, output pressure_pascal,
                   output divide_error, input ready);
   modport sink   (input valid, input temperature_tenths, input pressure_pascal,
                   input divide_error, output ready);
endinterface
`default_nettype wire

/* rtl/bsc_div.sv */
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module bsc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [bsc_pkg::WORD_W-1:0]   in_dividend,
   input  wire logic [bsc_pkg::WORD_W-1:0]   in_divisor,
   input  wire bsc_pkg::div_side_type        in_side,
   output logic [bsc_pkg::WORD_W-1:0]        out_quotient,
   output bsc_pkg::div_side_type             out_side
);
   import bsc_pkg::*;

   logic [WORD_W-1:0] rem_ff [DIV_STEPS];
   logic [WORD_W-1:0] quo_ff [DIV_STEPS];
   logic [WORD_W-1:0] dvs_ff [DIV_STEPS];
   div_side_type      side_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [WORD_W-1:0] rem_prev;
      logic [WORD_W-1:0] quo_prev;
      logic [WORD_W-1:0] dvs_prev;
      div_side_type      side_prev;
      logic [WORD_W:0]   trial;
      logic              fits;
      logic [WORD_W-1:0] rem_in;
      logic [WORD_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign quo_prev  = in_dividend;
         assign dvs_prev  = in_divisor;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign quo_prev  = quo_ff[i-1];
         assign dvs_prev  = dvs_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // Bring down the next dividend bit and subtract the divisor when it fits.
      assign trial  = {rem_prev, quo_prev[WORD_W-1]};
      assign fits   = trial >= {1'b0, dvs_prev};
      assign rem_in = fits ? WORD_W'(trial - {1'b0, dvs_prev}) : trial[WORD_W-1:0];
      assign quo_in = {quo_prev[WORD_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else if (advance) begin
            side_ff[i] <= side_prev;
         end
         if (advance) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
            dvs_ff[i] <= dvs_prev;
         end
      end
   end

   assign out_quotient = quo_ff[DIV_STEPS-1];
   assign out_side     = side_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

/* rtl/barometric_sensor_compensation.sv */
// Top level of the barometric sensor temperature and pressure compensation pipeline.
//
// Usage: the req_if channel takes one word per sample holding the raw temperature word
// and the raw 24-bit pressure reading; the rsp_if channel returns one word per sample
// with the temperature in tenths of a degree, the pressure in pascals and a flag that
// is set when either division met a zero divisor (the pressure then reads 0).
// Coefficients and the oversampling mode are written through the csr_ port by index
// while no sample is in flight; they all reset to zero.
// From acceptance to the response word being shown, a sample passes fifteen arithmetic
// stages and two 32-stage bit-per-stage dividers. While the response word does not stall,
// a new sample can be taken in every cycle, so the sustained rate is one word per cycle.
// The whole pipeline moves as one: when the response word waits on a low rsp_if.ready,
// every stage holds and req_if.ready drops, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bsc_req_if.sink                                req_if,
   bsc_rsp_if.source                              rsp_if,
   input  wire logic                              csr_write_enable,
   input  wire logic [bsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bsc_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import bsc_pkg::*;
   `include "barometric_sensor_compensation_macros.svh"

   // Configuration registers.
   logic [MODE_W-1:0]     mode_ff;
   logic [CSR_DATA_W-1:0] coeff_a_ff;
   logic [CSR_DATA_W-1:0] coeff_b_ff;
   logic [WORD_W-1:0]     coeff_c_ff;
   logic [WORD_W-1:0]     coeff_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         coeff_a_ff <= '0;
         coeff_b_ff <= '0;
         coeff_c_ff <= '0;
         coeff_d_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff    <= csr_write_data[MODE_W-1:0];
            CSR_COEFF_A: coeff_a_ff <= csr_write_data;
            CSR_COEFF_B: coeff_b_ff <= csr_write_data;
            CSR_COEFF_C: coeff_c_ff <= csr_write_data[WORD_W-1:0];
            CSR_COEFF_D: coeff_d_ff <= csr_write_data[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   // Coefficients unpacked to 32 bits. The user must keep the configuration stable while
   // samples are in flight (the block does not enforce it); every stage reads them directly.
   logic [WORD_W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sext16(coeff_a_ff[47:32]);
   assign ac2 = sext16(coeff_a_ff[31:16]);
   assign ac3 = sext16(coeff_a_ff[15:0]);
   assign ac4 = {16'd0, coeff_b_ff[47:32]};
   assign ac5 = {16'd0, coeff_b_ff[31:16]};
   assign ac6 = {16'd0, coeff_b_ff[15:0]};
   assign b1  = sext16(coeff_c_ff[31:16]);
   assign b2  = sext16(coeff_c_ff[15:0]);
   assign mc  = sext16(coeff_d_ff[31:16]);
   assign md  = sext16(coeff_d_ff[15:0]);

   // Global advance: the output register is empty or its word is being taken.
   logic rsp_valid_ff;
   logic advance;
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // Valid bits of the stages outside the dividers.
   logic [14:1] vld_ff;
   logic [14:1] vld_in;

   // Stage 1: first temperature product and the mode-scaled pressure reading.
   logic [WORD_W-1:0] s1_prod_ff, s1_prod_in;
   logic [UP_W-1:0]   s1_up_ff, s1_up_in;
   // Stage 2: x1 and the first divisor.
   logic [WORD_W-1:0] s2_x1_ff, s2_x1_in, s2_den_ff, s2_den_in;
   logic [UP_W-1:0]   s2_up_ff;
   // Stage 3: magnitudes and signs ahead of the first divider.
   logic [WORD_W-1:0] s3_num_ff, s3_num_in, s3_den_ff, s3_den_in;
   div_side_type      s3_side_ff, s3_side_in;
   // First divider outputs.
   logic [WORD_W-1:0] d1_quo;
   div_side_type      d1_side;
   // Stage 4: b5.
   logic [WORD_W-1:0] s4_b5_ff, s4_b5_in;
   logic [UP_W-1:0]   s4_up_ff;
   logic              s4_err_ff;
   // Stage 5: temperature and b6.
   logic [WORD_W-1:0] s5_temp_ff, s5_temp_in, s5_b6_ff, s5_b6_in;
   logic [UP_W-1:0]   s5_up_ff;
   logic              s5_err_ff;
   // Stage 6: products of b6.
   logic [WORD_W-1:0] s6_sq_ff, s6_sq_in, s6_a2_ff, s6_a2_in, s6_a3_ff, s6_a3_in;
   logic [WORD_W-1:0] s6_temp_ff;
   logic [UP_W-1:0]   s6_up_ff;
   logic              s6_err_ff;
   // Stage 7: products of the squared term.
   logic [WORD_W-1:0] s7_b2p_ff, s7_b2p_in, s7_b1p_ff, s7_b1p_in;
   logic [WORD_W-1:0] s7_x2_ff, s7_x2_in, s7_x1_ff, s7_x1_in, s7_temp_ff;
   logic [UP_W-1:0]   s7_up_ff;
   logic              s7_err_ff;
   // Stage 8: the two x3 terms.
   logic [WORD_W-1:0] s8_x3a_ff, s8_x3a_in, s8_x3b_ff, s8_x3b_in, s8_temp_ff;
   logic [UP_W-1:0]   s8_up_ff;
   logic              s8_err_ff;
   // Stage 9: b3 and the b4 product.
   logic [WORD_W-1:0] s9_b3_ff, s9_b3_in, s9_b4p_ff, s9_b4p_in, s9_temp_ff;
   logic [UP_W-1:0]   s9_up_ff;
   logic              s9_err_ff;
   // Stage 10: b4 and the pressure difference.
   logic [WORD_W-1:0] s10_b4_ff, s10_b4_in, s10_diff_ff, s10_diff_in, s10_temp_ff;
   logic              s10_err_ff;
   // Stage 11: b7.
   logic [WORD_W-1:0] s11_b7_ff, s11_b7_in, s11_b4_ff, s11_temp_ff;
   logic              s11_err_ff;
   // Second divider inputs and outputs.
   logic [WORD_W-1:0] d2_num;
   div_side_type      d2_side_in;
   logic [WORD_W-1:0] d2_quo;
   div_side_type      d2_side;
   // Stage 12: pressure estimate p.
   logic [WORD_W-1:0] s12_p_ff, s12_p_in, s12_temp_ff;
   logic              s12_err_ff;
   // Stage 13: polynomial products.
   logic [WORD_W-1:0] s13_pp_ff, s13_pp_in, s13_lin_ff, s13_lin_in, s13_p_ff, s13_temp_ff;
   logic              s13_err_ff;
   // Stage 14: scaled square term.
   logic [WORD_W-1:0] s14_sq_ff, s14_sq_in, s14_x2_ff, s14_x2_in, s14_p_ff, s14_temp_ff;
   logic              s14_err_ff;
   // Stage 15: response register.
   logic [WORD_W-1:0] rsp_temp_ff, rsp_pres_ff, rsp_pres_in;
   logic              rsp_err_ff;

   logic [WORD_W-1:0] mb_pre, p_shr, num_raw;
   logic              den_zero;

   always_comb begin
      // Stage 1
      s1_prod_in = WORD_W'(({16'd0, req_if.raw_temperature} - ac6) * ac5);
      s1_up_in   = req_if.raw_pressure >> (4'd8 - {2'd0, mode_ff});
      // Stage 2
      s2_x1_in   = sar32(s1_prod_ff, 15);
      s2_den_in  = sar32(s1_prod_ff, 15) + md;
      // Stage 3: signed division turned into magnitudes plus a sign.
      num_raw    = mc << 11;
      den_zero   = (s2_den_ff == '0);
      s3_num_in  = num_raw[WORD_W-1] ? WORD_W'(-num_raw) : num_raw;
      mb_pre     = s2_den_ff[WORD_W-1] ? WORD_W'(-s2_den_ff) : s2_den_ff;
      s3_den_in  = mb_pre;
      s3_side_in.valid = vld_ff[2];
      s3_side_in.err   = den_zero;
      s3_side_in.flag  = num_raw[WORD_W-1] ^ s2_den_ff[WORD_W-1];
      s3_side_in.word  = s2_x1_ff;
      s3_side_in.up    = s2_up_ff;
      // Stage 4: a zero divisor yields a zero quotient.
      if (d1_side.err) begin
         s4_b5_in = d1_side.word;
      end else if (d1_side.flag) begin
         s4_b5_in = d1_side.word - d1_quo;
      end else begin
         s4_b5_in = d1_side.word + d1_quo;
      end
      // Stage 5
      s5_temp_in = sar32(s4_b5_ff + 32'd8, 4);
      s5_b6_in   = s4_b5_ff - TEMP_OFFSET;
      // Stage 6
      s6_sq_in   = WORD_W'(s5_b6_ff * s5_b6_ff);
      s6_a2_in   = WORD_W'(ac2 * s5_b6_ff);
      s6_a3_in   = WORD_W'(ac3 * s5_b6_ff);
      // Stage 7
      s7_b2p_in  = WORD_W'(b2 * sar32(s6_sq_ff, 12));
      s7_b1p_in  = WORD_W'(b1 * sar32(s6_sq_ff, 12));
      s7_x2_in   = sar32(s6_a2_ff, 11);
      s7_x1_in   = sar32(s6_a3_ff, 13);
      // Stage 8
      s8_x3a_in  = sar32(s7_b2p_ff, 11) + s7_x2_ff;
      s8_x3b_in  = sar32(s7_x1_ff + sar32(s7_b1p_ff, 16) + 32'd2, 2);
      // Stage 9
      s9_b3_in   = sar32((((ac1 << 2) + s8_x3a_ff) << mode_ff) + 32'd2, 2);
      s9_b4p_in  = WORD_W'(ac4 * (s8_x3b_ff + HALF_SCALE));
      // Stage 10
      s10_b4_in   = s9_b4p_ff >> 15;
      s10_diff_in = {8'd0, s9_up_ff} - s9_b3_ff;
      // Stage 11
      s11_b7_in   = WORD_W'(s10_diff_ff * (OSS_FACTOR >> mode_ff));
      // Second divider: doubling before the divide while it cannot overflow.
      d2_num            = (s11_b7_ff >= SIGN_BIT) ? s11_b7_ff : (s11_b7_ff << 1);
      d2_side_in.valid  = vld_ff[11];
      d2_side_in.err    = s11_err_ff || (s11_b4_ff == '0);
      d2_side_in.flag   = (s11_b7_ff >= SIGN_BIT);
      d2_side_in.word   = s11_temp_ff;
      d2_side_in.up     = '0;
      // Stage 12
      s12_p_in   = d2_side.flag ? (d2_quo << 1) : d2_quo;
      // Stage 13
      p_shr      = sar32(s12_p_ff, 8);
      s13_pp_in  = WORD_W'(p_shr * p_shr);
      s13_lin_in = WORD_W'(POLY_LIN * s12_p_ff);
      // Stage 14
      s14_sq_in  = WORD_W'(s13_pp_ff * POLY_SQ);
      s14_x2_in  = sar32(s13_lin_ff, 16);
      // Stage 15
      if (s14_err_ff) begin
         rsp_pres_in = '0;
      end else begin
         rsp_pres_in = s14_p_ff + sar32(sar32(s14_sq_ff, 16) + s14_x2_ff + POLY_OFFSET, 4);
      end
      // Valid chain; the dividers carry their own valid bits.
      vld_in      = {vld_ff[13:12], d2_side.valid, vld_ff[10:4], d1_side.valid,
                     vld_ff[2], vld_ff[1], req_if.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[14];
      end
   end

   // Stage 3 side carries its own valid bit into the first divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_side_ff <= s3_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= s1_prod_in;   s1_up_ff    <= s1_up_in;
         s2_x1_ff    <= s2_x1_in;     s2_den_ff   <= s2_den_in;   s2_up_ff   <= s1_up_ff;
         s3_num_ff   <= s3_num_in;    s3_den_ff   <= s3_den_in;
         s4_b5_ff    <= s4_b5_in;     s4_up_ff    <= d1_side.up;  s4_err_ff  <= d1_side.err;
         s5_temp_ff  <= s5_temp_in;   s5_b6_ff    <= s5_b6_in;
         s5_up_ff    <= s4_up_ff;     s5_err_ff   <= s4_err_ff;
         s6_sq_ff    <= s6_sq_in;     s6_a2_ff    <= s6_a2_in;    s6_a3_ff   <= s6_a3_in;
         s6_temp_ff  <= s5_temp_ff;   s6_up_ff    <= s5_up_ff;    s6_err_ff  <= s5_err_ff;
         s7_b2p_ff   <= s7_b2p_in;    s7_b1p_ff   <= s7_b1p_in;
         s7_x2_ff    <= s7_x2_in;     s7_x1_ff    <= s7_x1_in;    s7_temp_ff <= s6_temp_ff;
         s7_up_ff    <= s6_up_ff;     s7_err_ff   <= s6_err_ff;
         s8_x3a_ff   <= s8_x3a_in;    s8_x3b_ff   <= s8_x3b_in;   s8_temp_ff <= s7_temp_ff;
         s8_up_ff    <= s7_up_ff;     s8_err_ff   <= s7_err_ff;
         s9_b3_ff    <= s9_b3_in;     s9_b4p_ff   <= s9_b4p_in;   s9_temp_ff <= s8_temp_ff;
         s9_up_ff    <= s8_up_ff;     s9_err_ff   <= s8_err_ff;
         s10_b4_ff   <= s10_b4_in;    s10_diff_ff <= s10_diff_in;
         s10_temp_ff <= s9_temp_ff;   s10_err_ff  <= s9_err_ff;
         s11_b7_ff   <= s11_b7_in;    s11_b4_ff   <= s10_b4_ff;
         s11_temp_ff <= s10_temp_ff;  s11_err_ff  <= s10_err_ff;
         s12_p_ff    <= s12_p_in;     s12_temp_ff <= d2_side.word; s12_err_ff <= d2_side.err;
         s13_pp_ff   <= s13_pp_in;    s13_lin_ff  <= s13_lin_in;  s13_p_ff   <= s12_p_ff;
         s13_temp_ff <= s12_temp_ff;  s13_err_ff  <= s12_err_ff;
         s14_sq_ff   <= s14_sq_in;    s14_x2_ff   <= s14_x2_in;   s14_p_ff   <= s13_p_ff;
         s14_temp_ff <= s13_temp_ff;  s14_err_ff  <= s13_err_ff;
         rsp_temp_ff <= s14_temp_ff;  rsp_pres_ff <= rsp_pres_in; rsp_err_ff <= s14_err_ff;
      end
   end

   // Temperature divide: (mc << 11) / (x1 + md).
   bsc_div u_div_temp (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_dividend  (s3_num_ff),
      .in_divisor   (s3_den_ff),
      .in_side      (s3_side_ff),
      .out_quotient (d1_quo),
      .out_side     (d1_side)
   );

   // Pressure divide: b7 (doubled when small) over b4.
   bsc_div u_div_pres (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_dividend  (d2_num),
      .in_divisor   (s11_b4_ff),
      .in_side      (d2_side_in),
      .out_quotient (d2_quo),
      .out_side     (d2_side)
   );

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.temperature_tenths = rsp_temp_ff;
   assign rsp_if.pressure_pascal    = rsp_pres_ff;
   assign rsp_if.divide_error       = rsp_err_ff;

   `BSC_ASSERT_NOW(a_err_zero_pressure, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_pres_ff == '0, "pressure not zero on a divide error")
   `BSC_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(vld_ff) && $stable(s3_side_ff.valid), "pipeline valid bits moved during a stall")
   `BSC_ASSERT_NEXT(a_zero_den_flags, clock, reset, advance && vld_ff[2] && (s2_den_ff == '0), s3_side_ff.err, "zero temperature divisor not flagged")
   `BSC_ASSERT_NOW(a_div_valid_match, clock, reset, 1'b1, vld_ff[3] == s3_side_ff.valid, "stage 3 valid bits disagree")

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the barometric sensor compensation pipeline.
`timescale 1ns / 1ps
module testbench;
   import bsc_pkg::*;

   // One compensated reading as the block reports it.
   typedef struct {
      bit [31:0] temperature;
      bit [31:0] pressure;
      bit        div_error;
   } reading_type;

   // One raw sample as the sensor delivers it.
   typedef struct {
      bit [15:0] raw_temp;
      bit [23:0] raw_press;
   } sample_type;

   localparam int PIPE_LATENCY = 79;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   bsc_req_if req_ch();
   bsc_rsp_if rsp_ch();

   barometric_sensor_compensation dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // The testbench's own copy of the calibration registers.
   bit [1:0]  cal_mode;
   bit [47:0] cal_a;
   bit [47:0] cal_b;
   bit [31:0] cal_c;
   bit [31:0] cal_d;

   sample_type  raw_samples[$];     // samples waiting to be offered on the request channel
   reading_type due_readings[$];    // readings owed by the block, oldest first
   int       error_count;
   int       idle_cycles;
   int       sender_idle_pct;
   int       receiver_stall_pct;
   bit       hold_phase;
   bit       hold_done;
   int       hold_left;

   // Arithmetic right shift of a 32-bit word.
   function automatic bit [31:0] shift_arith(bit [31:0] v, int n);
      return $signed(v) >>> n;
   endfunction

   function automatic bit [31:0] widen16(bit [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Signed division truncating toward zero; a zero divisor gives 0 and sets the flag.
   function automatic bit [31:0] div_trunc(bit [31:0] num, bit [31:0] den, ref bit err);
      bit [31:0] mag_n, mag_d, quo;
      if (den == 0) begin
         err = 1;
         return 0;
      end
      mag_n = num[31] ? -num : num;
      mag_d = den[31] ? -den : den;
      quo = mag_n / mag_d;
      return (num[31] != den[31]) ? -quo : quo;
   endfunction

   // Datasheet integer compensation with 32-bit wrapping arithmetic throughout.
   function automatic reading_type compensate(sample_type s);
      reading_type r;
      bit [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      bit [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq;
      bit err;
      err = 0;
      ac1 = widen16(cal_a[47:32]);
      ac2 = widen16(cal_a[31:16]);
      ac3 = widen16(cal_a[15:0]);
      ac4 = {16'b0, cal_b[47:32]};
      ac5 = {16'b0, cal_b[31:16]};
      ac6 = {16'b0, cal_b[15:0]};
      b1 = widen16(cal_c[31:16]);
      b2 = widen16(cal_c[15:0]);
      mc = widen16(cal_d[31:16]);
      md = widen16(cal_d[15:0]);
      ut = {16'b0, s.raw_temp};
      up = {8'b0, s.raw_press} >> (8 - cal_mode);

      x1 = shift_arith((ut - ac6) * ac5, 15);
      x2 = div_trunc(mc << 11, x1 + md, err);
      b5 = x1 + x2;
      r.temperature = shift_arith(b5 + 8, 4);

      b6 = b5 - 32'd4000;
      sq = shift_arith(b6 * b6, 12);
      x1 = shift_arith(b2 * sq, 11);
      x2 = shift_arith(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shift_arith(((ac1 * 4 + x3) << cal_mode) + 2, 2);
      x1 = shift_arith(ac3 * b6, 13);
      x2 = shift_arith(b1 * sq, 16);
      x3 = shift_arith(x1 + x2 + 2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      b7 = (up - b3) * (32'd50000 >> cal_mode);

      if (b4 == 0) begin
         err = 1;
         p = 0;
      end else if (b7 < 32'h8000_0000) begin
         p = (b7 << 1) / b4;
      end else begin
         p = (b7 / b4) << 1;
      end

      if (err) begin
         r.pressure = 0;
      end else begin
         x1 = shift_arith(p, 8) * shift_arith(p, 8);
         x1 = shift_arith(x1 * 32'd3038, 16);
         x2 = shift_arith((-32'd7357) * p, 16);
         r.pressure = p + shift_arith(x1 + x2 + 32'd3791, 4);
      end
      r.div_error = err;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Request driver: a word leaves the queue only once the previous one was taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
         req_ch.raw_temperature <= 0;
         req_ch.raw_pressure <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_readings.push_back(compensate('{req_ch.raw_temperature,
                                                req_ch.raw_pressure}));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (raw_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               sample_type s;
               s = raw_samples.pop_front();
               req_ch.valid <= 1;
               req_ch.raw_temperature <= s.raw_temp;
               req_ch.raw_pressure <= s.raw_press;
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here while the sender keeps offering words.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_phase && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
      end
   end

   // Response monitor: checks each word and paces rsp ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_readings.size() == 0) begin
               $display("%0t: unexpected word temp=%0d press=%0d err=%0d", $time,
                        rsp_ch.temperature_tenths, rsp_ch.pressure_pascal,
                        rsp_ch.divide_error);
               error_count++;
            end else begin
               reading_type want;
               want = due_readings.pop_front();
               if (rsp_ch.temperature_tenths !== want.temperature) begin
                  $display("%0t: temperature expected %0d got %0d", $time,
                           $signed(want.temperature), rsp_ch.temperature_tenths);
                  error_count++;
               end
               if (rsp_ch.pressure_pascal !== want.pressure) begin
                  $display("%0t: pressure expected %0d got %0d", $time,
                           $signed(want.pressure), rsp_ch.pressure_pascal);
                  error_count++;
               end
               if (rsp_ch.divide_error !== want.div_error) begin
                  $display("%0t: divide error expected %0d got %0d", $time,
                           want.div_error, rsp_ch.divide_error);
                  error_count++;
               end
            end
         end
         if (hold_left > 0 || (hold_phase && !hold_done)) begin
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: too long without a word crossing either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Writes one calibration register and mirrors it into the predictor's copy.
   task automatic write_reg(csr_index_type idx, bit [47:0] value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_MODE:    cal_mode = value[1:0];
         CSR_COEFF_A: cal_a = value;
         CSR_COEFF_B: cal_b = value;
         CSR_COEFF_C: cal_c = value[31:0];
         CSR_COEFF_D: cal_d = value[31:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic load_calibration(bit [1:0] mode, bit [47:0] a, bit [47:0] b,
                                   bit [31:0] c, bit [31:0] d);
      write_reg(CSR_MODE, {46'b0, mode});
      write_reg(CSR_COEFF_A, a);
      write_reg(CSR_COEFF_B, b);
      write_reg(CSR_COEFF_C, c);
      write_reg(CSR_COEFF_D, d);
   endtask

   // Waits until every queued sample was taken and every reading has come back.
   task automatic drain();
      wait (raw_samples.size() == 0 && !req_ch.valid && due_readings.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_sample(bit [15:0] t, bit [23:0] p);
      raw_samples.push_back('{t, p});
   endtask

   // Typical calibration: ac1..ac3, ac4..ac6, b1 b2, mc md.
   localparam bit [47:0] TYP_A = {16'd408, -16'sd72, -16'sd14383};
   localparam bit [47:0] TYP_B = {16'd32741, 16'd32757, 16'd23153};
   localparam bit [31:0] TYP_C = {16'd6190, 16'd4};
   localparam bit [31:0] TYP_D = {-16'sd8711, 16'd2868};

   initial begin
      int kind;
      reset = 1;
      csr_write_enable = 0;
      csr_index = CSR_MODE;
      csr_write_data = 0;
      error_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_phase = 0;
      cal_mode = 0;
      cal_a = 0;
      cal_b = 0;
      cal_c = 0;
      cal_d = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // With every coefficient at its reset value of zero, both divisors are zero.
      add_sample(16'h0000, 24'h000000);
      add_sample(16'hFFFF, 24'hFFFFFF);
      drain();

      // Directed corners under typical calibration at the lowest and highest modes.
      load_calibration(2'd0, TYP_A, TYP_B, TYP_C, TYP_D);
      add_sample(16'd27898, {16'd23843, 8'h00});
      add_sample(16'h0000, 24'h000000);
      add_sample(16'hFFFF, 24'hFFFFFF);
      add_sample(16'h8000, 24'h800000);
      add_sample(16'h7FFF, 24'h7FFFFF);
      add_sample(16'd23153, 24'h5D2300);
      drain();
      load_calibration(2'd3, TYP_A, TYP_B, TYP_C, TYP_D);
      add_sample(16'd27898, {16'd23843, 8'hA5});
      add_sample(16'h0000, 24'hFFFFFF);
      add_sample(16'hFFFF, 24'h000000);
      drain();

      // Pressure divisor zero alone: ac4 cleared, temperature path still valid.
      load_calibration(2'd1, TYP_A, {16'd0, TYP_B[31:0]}, TYP_C, TYP_D);
      add_sample(16'd27898, 24'h5D2300);
      add_sample(16'hFFFF, 24'hFFFFFF);
      // All-ones coefficients at the top mode.
      drain();
      load_calibration(2'd3, '1, '1, '1, '1);
      add_sample(16'h0000, 24'h000000);
      add_sample(16'hFFFF, 24'hFFFFFF);
      add_sample(16'd30000, 24'h123456);
      drain();

      // Random phases: the idling pattern rotates, calibration changes between phases.
      for (int ph = 0; ph < 8; ph++) begin
         kind = ph % 4;
         sender_idle_pct = (kind == 1) ? 77 : (kind == 3) ? 33 : 0;
         receiver_stall_pct = (kind == 2) ? 77 : (kind == 3) ? 33 : 0;
         hold_phase = (ph == 4);
         case (ph % 3)
            0: load_calibration(2'($urandom_range(3)), TYP_A, TYP_B, TYP_C, TYP_D);
            1: load_calibration(2'($urandom_range(3)),
                                48'({$urandom(), $urandom()}),
                                48'({$urandom(), $urandom()}),
                                $urandom(), $urandom());
            default: load_calibration(2'($urandom_range(3)),
                                      {TYP_A[47:16], 16'($urandom())},
                                      {16'($urandom_range(20000, 40000)), TYP_B[31:0]},
                                      {16'($urandom_range(1000, 9000)), 16'($urandom())},
                                      TYP_D);
         endcase
         for (int n = 0; n < 115; n++) begin
            // Mostly realistic readings, the rest spread over the full field ranges.
            if ($urandom_range(99) < 70)
               add_sample(16'($urandom_range(20000, 36000)),
                          24'($urandom_range(24'h400000, 24'hA00000)));
            else
               add_sample(16'($urandom()), 24'($urandom()));
         end
         drain();
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
